// ===== hdl/angle_between_vectors_2d_unit_assert.svh =====
// assertion helpers for the vector angle unit
// every property is sampled on the rising clock and muted while reset is low
`ifndef ANGLE_BETWEEN_VECTORS_2D_UNIT_ASSERT_SVH
`define ANGLE_BETWEEN_VECTORS_2D_UNIT_ASSERT_SVH

// property that must hold at every sampled edge
`define ABV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property that must hold in the cycle after a condition
`define ABV_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== hdl/abv2d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package abv2d_pkg;

	// width of dot and cross after the product prescale
	localparam int DC_W = 33;
	// cordic x/y datapath, inputs scaled up by CORDIC_PRESHIFT
	localparam int XY_W = 63;
	localparam int CORDIC_PRESHIFT = 29;
	// accumulated cordic angle, q2.30 signed
	localparam int Z_W = 32;
	// base angle, q2.30 unsigned
	localparam int BASE_W = 32;
	// base plus accumulated angle plus rounding term
	localparam int TOT_W = BASE_W + 2;
	localparam int ANG_FRAC = 30;
	localparam int CORDIC_STAGES = 31;

	localparam logic [BASE_W-1:0] PI_Q30 = 32'd3373259426;
	localparam logic [BASE_W-1:0] HALF_PI_Q30 = 32'd1686629713;

	// atan(2^-i) in q2.30 for the first rotations, later ones are 2^(30-i)
	localparam logic [29:0] ATAN_HEAD [10] = '{
		30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
		30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149
	};

	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Z_W-1:0] z_t;

	// side data that rides along the cordic chain
	typedef struct packed {
		logic degenerate;
		logic [BASE_W-1:0] base;
	} tag_t;

	function automatic z_t atan_q30(input int i);
		z_t r;
		if (i < 10) begin
			r = z_t'(ATAN_HEAD[i[3:0]]);
		end else begin
			r = z_t'(1) <<< (ANG_FRAC - i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/angle_between_vectors_2d_unit.sv =====
// angle between two 2d vectors, q2.x radians via a vectoring cordic on (dot, |cross|)
// an accepted input passes the registers of stages 1 to 3, the cordic stages and the output register
// throughput: one transaction per cycle while the output is not stalled; the cordic has 31 one-rotation stages
// a stall at the output fills empty stages first, input stalls only when all are full
// reset (arst_n low, asynchronous) empties every stage; no payload state is kept
`timescale 1ns / 1ps
`default_nettype none
`include "angle_between_vectors_2d_unit_assert.svh"

module angle_between_vectors_2d_unit #(
	parameter int COMPONENT_BITS = 16,
	parameter int ANGLE_FRACTION_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [COMPONENT_BITS-1:0] a_x,
	input logic signed [COMPONENT_BITS-1:0] a_y,
	input logic signed [COMPONENT_BITS-1:0] b_x,
	input logic signed [COMPONENT_BITS-1:0] b_y,
	output logic out_valid,
	input logic out_stall,
	output logic [ANGLE_FRACTION_BITS+1:0] angle,
	output logic degenerate
);
	import abv2d_pkg::*;

	localparam int PW = 2 * COMPONENT_BITS;
	localparam int PRE = (PW > 32) ? (PW - 32) : 0;
	localparam int WW = (PW > DC_W) ? PW : DC_W;
	localparam int SH = ANG_FRAC - ANGLE_FRACTION_BITS;
	localparam int AW = ANGLE_FRACTION_BITS + 2;
	localparam logic signed [TOT_W-1:0] HALF_R = TOT_W'(1) <<< (SH - 1);
	localparam logic signed [TOT_W-1:0] PI_OUT =
		(TOT_W'(PI_Q30) + HALF_R) >>> SH;

	// floor prescale of one product into the dot/cross width
	function automatic logic signed [DC_W-1:0] pre_shift(input logic signed [PW-1:0] p);
		logic signed [WW-1:0] e;
		e = WW'(p);
		e = e >>> PRE;
		return e[DC_W-1:0];
	endfunction

	// stage enables, a stage loads when empty or when it drains onward
	logic en_s1, en_s2, en_s3, en_s5;
	logic en_c [CORDIC_STAGES];

	// stage 1 registers
	logic v_s1;
	logic deg_s1;
	logic signed [PW-1:0] pxx_s1, pyy_s1, pxy_s1, pyx_s1;

	// stage 2 registers
	logic v_s2;
	logic deg_s2, par_s2, perp_s2, neg_s2;
	logic signed [DC_W-1:0] dot_s2, cross_s2;
	logic signed [PW:0] sum_exact;

	// stage 3 registers
	logic v_s3;
	xy_t x_s3, y_s3;
	tag_t tag_s3;
	logic signed [DC_W-1:0] cross_abs, xv, yv;
	logic [BASE_W-1:0] base_v;

	// cordic chain
	logic vld_c [CORDIC_STAGES+1];
	xy_t x_c [CORDIC_STAGES+1];
	xy_t y_c [CORDIC_STAGES+1];
	z_t z_c [CORDIC_STAGES+1];
	tag_t tag_c [CORDIC_STAGES+1];

	// output stage
	logic valid_s5;
	logic [AW-1:0] angle_s5;
	logic degenerate_s5;
	logic signed [TOT_W-1:0] tot, rnd, ang;

	// enable chain from the output back to the input
	always_comb begin
		en_s5 = !valid_s5 || !out_stall;
		en_c[CORDIC_STAGES-1] = !vld_c[CORDIC_STAGES] || en_s5;
		for (int k = CORDIC_STAGES - 2; k >= 0; k--) begin
			en_c[k] = !vld_c[k+1] || en_c[k+1];
		end
		en_s3 = !v_s3 || en_c[0];
		en_s2 = !v_s2 || en_s3;
		en_s1 = !v_s1 || en_s2;
	end

	assign in_stall = !en_s1;

	// valid bits of the front stages and the output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s5) valid_s5 <= vld_c[CORDIC_STAGES];
		end
	end

	// stage 1: four products and zero vector detect
	always_ff @(posedge clk) begin
		if (en_s1) begin
			pxx_s1 <= a_x * b_x;
			pyy_s1 <= a_y * b_y;
			pxy_s1 <= a_x * b_y;
			pyx_s1 <= a_y * b_x;
			deg_s1 <= ((a_x == '0) && (a_y == '0)) || ((b_x == '0) && (b_y == '0));
		end
	end

	// stage 2: exact tests for parallel and perpendicular, prescaled dot and cross
	assign sum_exact = (PW+1)'(pxx_s1) + (PW+1)'(pyy_s1);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			deg_s2 <= deg_s1;
			par_s2 <= (pxy_s1 == pyx_s1);
			perp_s2 <= (sum_exact == '0);
			neg_s2 <= sum_exact[PW] || ((sum_exact == '0) && pxx_s1[PW-1]);
			dot_s2 <= pre_shift(pxx_s1) + pre_shift(pyy_s1);
			cross_s2 <= pre_shift(pxy_s1) - pre_shift(pyx_s1);
		end
	end

	// stage 3: fold into the right half plane, special cases start with y at zero
	always_comb begin
		cross_abs = cross_s2[DC_W-1] ? -cross_s2 : cross_s2;
		xv = '0;
		yv = '0;
		base_v = '0;
		if (deg_s2) begin
			base_v = '0;
		end else if (par_s2) begin
			base_v = neg_s2 ? PI_Q30 : '0;
		end else if (perp_s2) begin
			base_v = HALF_PI_Q30;
		end else if (dot_s2[DC_W-1]) begin
			xv = cross_abs;
			yv = -dot_s2;
			base_v = HALF_PI_Q30;
		end else begin
			xv = dot_s2;
			yv = cross_abs;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			x_s3 <= XY_W'(xv) <<< CORDIC_PRESHIFT;
			y_s3 <= XY_W'(yv) <<< CORDIC_PRESHIFT;
			tag_s3.degenerate <= deg_s2;
			tag_s3.base <= base_v;
		end
	end

	// stage 4: one rotation per register stage
	assign vld_c[0] = v_s3;
	assign x_c[0] = x_s3;
	assign y_c[0] = y_s3;
	assign z_c[0] = '0;
	assign tag_c[0] = tag_s3;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		abv2d_cordic_stage #(
			.IDX(i)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(en_c[i]),
			.valid(vld_c[i]),
			.x(x_c[i]),
			.y(y_c[i]),
			.z(z_c[i]),
			.tag(tag_c[i]),
			.valid_s4(vld_c[i+1]),
			.x_s4(x_c[i+1]),
			.y_s4(y_c[i+1]),
			.z_s4(z_c[i+1]),
			.tag_s4(tag_c[i+1])
		);
	end

	// stage 5: add base, round half up, clamp to [0, pi]
	always_comb begin
		tot = TOT_W'({2'b00, tag_c[CORDIC_STAGES].base}) + TOT_W'(z_c[CORDIC_STAGES])
			+ HALF_R;
		rnd = tot >>> SH;
		if (rnd[TOT_W-1]) begin
			ang = '0;
		end else if (rnd > PI_OUT) begin
			ang = PI_OUT;
		end else begin
			ang = rnd;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			angle_s5 <= ang[AW-1:0];
			degenerate_s5 <= tag_c[CORDIC_STAGES].degenerate;
		end
	end

	assign out_valid = valid_s5;
	assign angle = angle_s5;
	assign degenerate = degenerate_s5;

	// checks
	`ABV_ASSERT(a_deg_angle_zero, out_valid && degenerate |-> angle == '0, "degenerate angle not 0")
	`ABV_ASSERT(a_angle_max, out_valid |-> angle <= PI_OUT[AW-1:0], "angle above pi")
	`ABV_ASSERT(a_stall_full, in_stall |-> out_valid && out_stall, "input stalled with room")
	`ABV_ASSERT_NEXT(a_enter_s1, in_valid && !in_stall, v_s1, "transaction lost at entry")

endmodule

`default_nettype wire

// ===== hdl/abv2d_cordic_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module abv2d_cordic_stage #(
	parameter int IDX = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid,
	input abv2d_pkg::xy_t x,
	input abv2d_pkg::xy_t y,
	input abv2d_pkg::z_t z,
	input abv2d_pkg::tag_t tag,
	output logic valid_s4,
	output abv2d_pkg::xy_t x_s4,
	output abv2d_pkg::xy_t y_s4,
	output abv2d_pkg::z_t z_s4,
	output abv2d_pkg::tag_t tag_s4
);
	import abv2d_pkg::*;

	localparam z_t ANGLE = atan_q30(IDX);

	xy_t xs;
	xy_t ys;
	logic y_pos;
	logic y_neg;

	// floor shifts of both coordinates and direction of rotation
	always_comb begin
		xs = x >>> IDX;
		ys = y >>> IDX;
		y_neg = y[XY_W-1];
		y_pos = !y[XY_W-1] && (y != '0);
	end

	// stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid;
		end
	end

	// one vectoring rotation, no move when y is already zero
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s4 <= tag;
			if (y_pos) begin
				x_s4 <= x + ys;
				y_s4 <= y - xs;
				z_s4 <= z + ANGLE;
			end else if (y_neg) begin
				x_s4 <= x - ys;
				y_s4 <= y + xs;
				z_s4 <= z - ANGLE;
			end else begin
				x_s4 <= x;
				y_s4 <= y;
				z_s4 <= z;
			end
		end
	end

endmodule

`default_nettype wire

// ===== dv/angle_between_vectors_2d_unit_tb.sv =====
`timescale 1ns / 1ps

module angle_between_vectors_2d_unit_tb;

	localparam int COMPONENT_BITS = 16;
	localparam int ANGLE_FRACTION_BITS = 14;
	localparam int ANGLE_W = ANGLE_FRACTION_BITS + 2;
	localparam int PRESCALE = (2 * COMPONENT_BITS > 32) ? (2 * COMPONENT_BITS - 32) : 0;
	localparam longint PI_Q30_VAL = 64'sd3373259426;
	localparam longint HALF_PI_Q30_VAL = 64'sd1686629713;
	localparam int Q30_FRAC = 30;
	localparam int ROTATIONS = 31;
	localparam int RANDOM_PAIRS = 1030;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 60;
	localparam int DIRECTED_COUNT = 22;

	typedef logic signed [COMPONENT_BITS-1:0] comp_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic degenerate;
	} angle_result_t;

	// receiver back-pressure patterns
	typedef enum logic [1:0] {
		RX_FLOW,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	// expected angles in order of accepted input transactions
	class angle_scoreboard;
		angle_result_t expected_angles[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		// q2.30 to output format, rounded half up, clamped to [0, pi]
		function logic [ANGLE_W-1:0] round_q30(input longint q);
			int sh;
			longint pi_out;
			longint r;
			sh = Q30_FRAC - ANGLE_FRACTION_BITS;
			pi_out = (PI_Q30_VAL + (64'sd1 <<< (sh - 1))) >>> sh;
			if (q < 0) begin
				q = 0;
			end
			r = (q + (64'sd1 <<< (sh - 1))) >>> sh;
			if (r > pi_out) begin
				r = pi_out;
			end
			return r[ANGLE_W-1:0];
		endfunction

		function longint rotation_angle(input int i);
			case (i)
				0: return 64'sd843314857;
				1: return 64'sd497837829;
				2: return 64'sd263043837;
				3: return 64'sd133525159;
				4: return 64'sd67021687;
				5: return 64'sd33543516;
				6: return 64'sd16775851;
				7: return 64'sd8388437;
				8: return 64'sd4194283;
				9: return 64'sd2097149;
				default: return 64'sd1 <<< (Q30_FRAC - i);
			endcase
		endfunction

		function angle_result_t predict_angle(input comp_t ax_in, input comp_t ay_in,
				input comp_t bx_in, input comp_t by_in);
			longint ax, ay, bx, by;
			longint pxx, pyy, pxy, pyx;
			longint dot, cross_v, x, y, z, base, xs, ys;
			bit neg;
			angle_result_t r;
			ax = ax_in;
			ay = ay_in;
			bx = bx_in;
			by = by_in;
			r.angle = '0;
			r.degenerate = 1'b0;
			// zero vector on either side
			if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
				r.degenerate = 1'b1;
				return r;
			end
			pxx = ax * bx;
			pyy = ay * by;
			pxy = ax * by;
			pyx = ay * bx;
			if (pxy == pyx) begin
				// parallel: 0 or pi by the sign of the exact dot product
				neg = (pxx < 0) ? (pyy <= -pxx) : (pyy < -pxx);
				r.angle = neg ? round_q30(PI_Q30_VAL) : '0;
			end else if (pxx == -pyy) begin
				// perpendicular
				r.angle = round_q30(HALF_PI_Q30_VAL);
			end else begin
				dot = (pxx >>> PRESCALE) + (pyy >>> PRESCALE);
				cross_v = (pxy >>> PRESCALE) - (pyx >>> PRESCALE);
				if (cross_v < 0) begin
					cross_v = -cross_v;
				end
				if (dot < 0) begin
					x = cross_v;
					y = -dot;
					base = HALF_PI_Q30_VAL;
				end else begin
					x = dot;
					y = cross_v;
					base = 0;
				end
				x = x <<< 29;
				y = y <<< 29;
				z = 0;
				// vectoring rotations toward the x axis
				for (int i = 0; i < ROTATIONS; i++) begin
					xs = x >>> i;
					ys = y >>> i;
					if (y > 0) begin
						x = x + ys;
						y = y - xs;
						z = z + rotation_angle(i);
					end else if (y < 0) begin
						x = x - ys;
						y = y + xs;
						z = z - rotation_angle(i);
					end
				end
				r.angle = round_q30(base + z);
			end
			return r;
		endfunction

		function void note_input(input comp_t ax, input comp_t ay, input comp_t bx,
				input comp_t by);
			expected_angles.push_back(predict_angle(ax, ay, bx, by));
		endfunction

		function void check_result(input logic [ANGLE_W-1:0] angle_out, input logic degen_out);
			angle_result_t exp_r;
			if (expected_angles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: unexpected result angle=%0d degenerate=%0b",
						angle_out, degen_out);
				end
				return;
			end
			exp_r = expected_angles.pop_front();
			if (angle_out !== exp_r.angle || degen_out !== exp_r.degenerate) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: angle exp=%0d act=%0d, degenerate exp=%0b act=%0b",
						exp_r.angle, angle_out, exp_r.degenerate, degen_out);
				end
			end
		endfunction

		function int pending();
			return expected_angles.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	comp_t a_x;
	comp_t a_y;
	comp_t b_x;
	comp_t b_y;
	logic out_valid;
	logic out_stall;
	logic [ANGLE_W-1:0] angle;
	logic degenerate;

	angle_scoreboard sb;
	int cycle_count;
	rx_mode_t rx_mode;
	int rx_left;
	int rx_phase;

	int directed_set[DIRECTED_COUNT][4] = '{
		'{0, 0, 100, 50},
		'{100, 50, 0, 0},
		'{0, 0, 0, 0},
		'{32767, 32767, 32767, 32767},
		'{-32768, -32768, -32768, -32768},
		'{32767, 32767, -32768, -32768},
		'{-32768, 0, 32767, 0},
		'{256, 0, 0, 256},
		'{-32768, 32767, -32767, -32768},
		'{1, 0, -1, 0},
		'{1, -1, -1, 1},
		'{1, 0, 1, 1},
		'{1, 0, -1, 1},
		'{1, 0, -1, -1},
		'{32767, -32768, -32768, 32767},
		'{32767, 32766, 32766, 32765},
		'{-32768, 1, -32768, -1},
		'{1, 0, -32768, 1},
		'{0, 1, 0, -1},
		'{32767, 0, 0, -32768},
		'{-1, -1, -1, -1},
		'{100, -200, 300, 400}
	};

	angle_between_vectors_2d_unit #(
		.COMPONENT_BITS(COMPONENT_BITS),
		.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.a_x(a_x),
		.a_y(a_y),
		.b_x(b_x),
		.b_y(b_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.angle(angle),
		.degenerate(degenerate)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// monitor accepted transactions on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_input(a_x, a_y, b_x, b_y);
			end
			if (out_valid && !out_stall) begin
				sb.check_result(angle, degenerate);
			end
		end
	end

	// receiver stall pattern, switches mode every so often
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(20, 300);
			out_stall <= 1'b0;
		end else begin
			rx_left <= rx_left - 1;
			rx_phase <= rx_phase + 1;
			case (rx_mode)
				RX_FLOW: out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 20);
				RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
				RX_PERIODIC: out_stall <= ((rx_phase % 8) < 3);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// one input transaction, held until accepted
	task automatic send_pair(input comp_t ax, input comp_t ay, input comp_t bx, input comp_t by);
		@(negedge clk);
		in_valid <= 1'b1;
		a_x <= ax;
		a_y <= ay;
		b_x <= bx;
		b_y <= by;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic int extreme_value();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return -1;
			3: return 0;
			4: return 1;
			default: return 256;
		endcase
	endfunction

	function automatic int small_signed(input int mag);
		return int'($urandom_range(0, 2 * mag)) - mag;
	endfunction

	// random vector pair, weighted toward the special geometries
	task automatic pick_pair(output comp_t ax, output comp_t ay, output comp_t bx,
			output comp_t by);
		int kind;
		int k;
		int ux, uy;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			ax = comp_t'($urandom);
			ay = comp_t'($urandom);
			bx = comp_t'($urandom);
			by = comp_t'($urandom);
		end else if (kind < 52) begin
			ax = comp_t'(small_signed(6));
			ay = comp_t'(small_signed(6));
			bx = comp_t'(small_signed(6));
			by = comp_t'(small_signed(6));
		end else if (kind < 64) begin
			// scaled copy, same or opposite direction
			ux = small_signed(181);
			uy = small_signed(181);
			k = small_signed(181);
			ax = comp_t'(ux * small_signed(1) + (ux == 0 && uy == 0 ? 1 : 0));
			ax = comp_t'(ux);
			ay = comp_t'(uy);
			bx = comp_t'(ux * k);
			by = comp_t'(uy * k);
		end else if (kind < 75) begin
			// rotated by a quarter turn and scaled
			ux = small_signed(181);
			uy = small_signed(181);
			k = small_signed(181);
			ax = comp_t'(ux);
			ay = comp_t'(uy);
			bx = comp_t'(-uy * k);
			by = comp_t'(ux * k);
		end else if (kind < 83) begin
			ax = comp_t'(extreme_value());
			ay = comp_t'(extreme_value());
			bx = comp_t'(extreme_value());
			by = comp_t'(extreme_value());
		end else if (kind < 88) begin
			// one zero vector
			ax = comp_t'($urandom);
			ay = comp_t'($urandom);
			if ($urandom_range(0, 1)) begin
				bx = '0;
				by = '0;
			end else begin
				bx = ax;
				by = ay;
				ax = '0;
				ay = '0;
			end
		end else if (kind < 94) begin
			// nearly opposite or nearly equal
			ax = comp_t'($urandom);
			ay = comp_t'($urandom);
			k = $urandom_range(0, 1) ? 1 : -1;
			bx = comp_t'(k * int'(ax) + small_signed(3));
			by = comp_t'(k * int'(ay) + small_signed(3));
		end else begin
			ax = comp_t'(small_signed(1024));
			ay = comp_t'(small_signed(1024));
			bx = comp_t'(small_signed(1024));
			by = comp_t'(small_signed(1024));
		end
	endtask

	// main sequence
	initial begin
		comp_t ax, ay, bx, by;
		int burst_left;
		sb = new();
		cycle_count = 0;
		rx_mode = RX_FLOW;
		rx_left = 0;
		rx_phase = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		a_x = '0;
		a_y = '0;
		b_x = '0;
		b_y = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		idle_gap(2);

		// directed corners
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			send_pair(comp_t'(directed_set[i][0]), comp_t'(directed_set[i][1]),
				comp_t'(directed_set[i][2]), comp_t'(directed_set[i][3]));
			if ($urandom_range(0, 3) == 0) begin
				idle_gap($urandom_range(1, 4));
			end
		end

		// random bursts with random gaps
		burst_left = $urandom_range(1, 40);
		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			pick_pair(ax, ay, bx, by);
			send_pair(ax, ay, bx, by);
			burst_left--;
			if (burst_left == 0) begin
				idle_gap($urandom_range(1, 15));
				burst_left = $urandom_range(1, 40);
			end
		end
		idle_gap(1);

		// drain
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
